// File: src/hbcv_pkg.sv
// Package: shared types and constants for the HSV box classifier with vote.
`default_nettype none
package hbcv_pkg;

   localparam int NUM_INPUTS = 5;
   localparam int NUM_BOXES  = 6;
   localparam int NUM_AXES   = 3;
   localparam int BOUND_W    = 10;
   localparam int CHAN_W     = 8;
   localparam int PIX_W      = NUM_AXES * CHAN_W;
   localparam int BOX_W      = 2 * NUM_AXES * BOUND_W;
   localparam int CODE_W     = 3;
   localparam int CNT_W      = 3;
   localparam int THR_W      = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = BOX_W;

   typedef logic [PIX_W-1:0]      pixel_type;
   typedef logic [BOX_W-1:0]      box_type;
   typedef logic [CODE_W-1:0]     code_type;
   typedef logic [CNT_W-1:0]      count_type;
   typedef logic [THR_W-1:0]      thresh_type;
   typedef logic [CSR_IDX_W-1:0]  csr_index_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   localparam csr_index_type CSR_BOX_BLUE   = 3'd0;
   localparam csr_index_type CSR_BOX_GREEN  = 3'd1;
   localparam csr_index_type CSR_BOX_YELLOW = 3'd2;
   localparam csr_index_type CSR_BOX_ORANGE = 3'd3;
   localparam csr_index_type CSR_BOX_WHITE  = 3'd4;
   localparam csr_index_type CSR_BOX_RED    = 3'd5;
   localparam csr_index_type CSR_VOTE_THR   = 3'd6;

   localparam code_type   CODE_NONE         = 3'd0;
   localparam thresh_type DEFAULT_THRESHOLD = 3'd3;

endpackage
`default_nettype wire

// File: src/hbcv_ifs.sv
// Interfaces: pixel request channel and classification response channel.
`default_nettype none
interface hbcv_req_if;
   import hbcv_pkg::*;
   logic      valid;
   logic      ready;
   pixel_type pixel_center;
   pixel_type pixel_left;
   pixel_type pixel_right;
   pixel_type pixel_up;
   pixel_type pixel_down;
   modport source (output valid, pixel_center, pixel_left, pixel_right, pixel_up,
                   pixel_down, input ready);
   modport sink (input valid, pixel_center, pixel_left, pixel_right, pixel_up,
                 pixel_down, output ready);
endinterface

interface hbcv_rsp_if;
   import hbcv_pkg::*;
   logic      valid;
   logic      ready;
   code_type  color_code;
   count_type agree_count;
   modport source (output valid, color_code, agree_count, input ready);
   modport sink (input valid, color_code, agree_count, output ready);
endinterface
`default_nettype wire

// File: src/hbcv_lane.sv
// Lane: classifies one HSV sample against the six color boxes, registered.
`default_nettype none
module hbcv_lane (
   input  logic                clock,
   input  logic                enable,
   input  hbcv_pkg::pixel_type pixel,
   input  hbcv_pkg::box_type   boxes [hbcv_pkg::NUM_BOXES],
   output hbcv_pkg::code_type  code_ff
);
   import hbcv_pkg::*;

   code_type code_in;

   function automatic logic box_hit(input pixel_type p, input box_type bx);
      logic signed [BOUND_W-1:0] x;
      logic signed [BOUND_W-1:0] lo;
      logic signed [BOUND_W-1:0] hi;
      logic                      hit;
      hit = 1'b1;
      for (int a = 0; a < NUM_AXES; a++) begin
         x  = $signed({{(BOUND_W-CHAN_W){1'b0}}, p[a*CHAN_W +: CHAN_W]});
         lo = $signed(bx[(2*a)*BOUND_W +: BOUND_W]);
         hi = $signed(bx[(2*a+1)*BOUND_W +: BOUND_W]);
         hit = hit & (x >= lo) & (x <= hi);
      end
      return hit;
   endfunction

   // last matching box wins
   always_comb begin
      code_in = CODE_NONE;
      for (int b = 0; b < NUM_BOXES; b++) begin
         if (box_hit(pixel, boxes[b])) begin
            code_in = code_type'(b + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         code_ff <= code_in;
      end
   end

endmodule
`default_nettype wire

// File: src/hbcv_merge.sv
// Merge: majority vote over the lane codes with first-to-reach tie break.
`default_nettype none
module hbcv_merge #(
   parameter int NUM_LANES = 5
) (
   input  hbcv_pkg::code_type   codes [NUM_LANES],
   input  hbcv_pkg::thresh_type threshold,
   output hbcv_pkg::code_type   color_code,
   output hbcv_pkg::count_type  agree_count
);
   import hbcv_pkg::*;

   count_type prefix [NUM_LANES];
   count_type top;
   code_type  winner;

   // running count of each lane's code up to and including that lane
   always_comb begin
      for (int k = 0; k < NUM_LANES; k++) begin
         prefix[k] = '0;
         for (int j = 0; j <= k; j++) begin
            if (codes[j] == codes[k]) begin
               prefix[k] = prefix[k] + count_type'(1);
            end
         end
      end
   end

   always_comb begin
      top = '0;
      for (int k = 0; k < NUM_LANES; k++) begin
         if (prefix[k] > top) begin
            top = prefix[k];
         end
      end
   end

   // earliest lane whose running count hits the top count
   always_comb begin
      winner = CODE_NONE;
      for (int k = NUM_LANES - 1; k >= 0; k--) begin
         if (prefix[k] == top) begin
            winner = codes[k];
         end
      end
   end

   assign agree_count = top;
   assign color_code  = (top >= threshold) ? winner : CODE_NONE;

endmodule
`default_nettype wire

// File: src/hsv_box_classify_vote5_top.sv
// Top level: HSV box classifier with five-sample majority vote.
//
// Takes one beat of five HSV samples per clock and returns one beat with the
// voted color code and the agreeing count. One lane per sample classifies
// against the six boxes into a register, then the vote stage compares the
// lane codes and registers the result. Sustained rate is one beat per
// cycle; a stalled response backs the pipeline up and drops req_chan.ready
// only once both stages hold data. The user must write box and threshold
// registers through the csr port while no beat is in flight; not enforced.
`default_nettype none
module hsv_box_classify_vote5_top #(
   parameter int NUM_SAMPLES = 5
) (
   input  logic                    clock,
   input  logic                    reset,
   hbcv_req_if.sink                req_chan,
   hbcv_rsp_if.source              rsp_chan,
   input  logic                    csr_wr_en,
   input  hbcv_pkg::csr_index_type csr_index,
   input  hbcv_pkg::csr_data_type  csr_wdata
);
   import hbcv_pkg::*;

   localparam int NUM_LANES = (NUM_SAMPLES < NUM_INPUTS) ? NUM_SAMPLES : NUM_INPUTS;

   box_type    box_ff [NUM_BOXES];
   box_type    box_in [NUM_BOXES];
   thresh_type thr_ff;
   thresh_type thr_in;

   logic      s1_valid_ff;
   logic      out_valid_ff;
   code_type  color_ff;
   count_type agree_ff;
   logic      adv_out;
   logic      adv_s1;

   pixel_type pix [NUM_INPUTS];
   code_type  lane_code [NUM_LANES];
   code_type  vote_code;
   count_type vote_count;

   // csr writes
   always_comb begin
      box_in = box_ff;
      thr_in = thr_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_BOX_BLUE, CSR_BOX_GREEN, CSR_BOX_YELLOW,
            CSR_BOX_ORANGE, CSR_BOX_WHITE, CSR_BOX_RED: begin
               box_in[csr_index] = csr_wdata;
            end
            CSR_VOTE_THR: begin
               thr_in = csr_wdata[THR_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < NUM_BOXES; b++) begin
            box_ff[b] <= '0;
         end
         thr_ff <= DEFAULT_THRESHOLD;
      end else begin
         box_ff <= box_in;
         thr_ff <= thr_in;
      end
   end

   // pipeline control
   assign adv_out        = !out_valid_ff || rsp_chan.ready;
   assign adv_s1         = !s1_valid_ff || adv_out;
   assign req_chan.ready = adv_s1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (adv_s1) begin
            s1_valid_ff <= req_chan.valid;
         end
         if (adv_out) begin
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   assign pix[0] = req_chan.pixel_center;
   assign pix[1] = req_chan.pixel_left;
   assign pix[2] = req_chan.pixel_right;
   assign pix[3] = req_chan.pixel_up;
   assign pix[4] = req_chan.pixel_down;

   for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
      hbcv_lane u_lane (
         .clock   (clock),
         .enable  (adv_s1 && req_chan.valid),
         .pixel   (pix[i]),
         .boxes   (box_ff),
         .code_ff (lane_code[i])
      );
   end

   hbcv_merge #(
      .NUM_LANES (NUM_LANES)
   ) u_merge (
      .codes       (lane_code),
      .threshold   (thr_ff),
      .color_code  (vote_code),
      .agree_count (vote_count)
   );

   always_ff @(posedge clock) begin
      if (adv_out && s1_valid_ff) begin
         color_ff <= vote_code;
         agree_ff <= vote_count;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.color_code  = color_ff;
   assign rsp_chan.agree_count = agree_ff;

   a_color_meets_thr: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.color_code != CODE_NONE |->
         rsp_chan.agree_count >= thr_ff)
      else $error("color reported below vote threshold");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |->
         rsp_chan.agree_count != '0 && rsp_chan.agree_count <= count_type'(NUM_LANES))
      else $error("agree count out of range");

   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> s1_valid_ff)
      else $error("accepted beat not captured by lanes");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && out_valid_ff && !rsp_chan.ready |-> !req_chan.ready)
      else $error("request taken while pipeline full");

endmodule
`default_nettype wire
